/* design/multi_source_pixel_compositor_macros.svh */
// Assertion macros used by the compositor checker.
`ifndef MULTI_SOURCE_PIXEL_COMPOSITOR_MACROS_SVH
`define MULTI_SOURCE_PIXEL_COMPOSITOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MSPC_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MSPC_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/mspc_pkg.sv */
// Types and constants of the multi-source pixel compositor.
`timescale 1ns / 1ps
package mspc_pkg;

    localparam int VALUE_W = 8;
    localparam int DIST_W = 16;
    localparam int LDIST_W = DIST_W + 1;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    // Register indexes on the configuration port
    localparam logic [1:0] CFG_METHOD = 2'd0;
    localparam logic [1:0] CFG_NODATA = 2'd1;
    localparam logic [1:0] CFG_UNDETECT = 2'd2;

    // Sample classes
    localparam logic [1:0] CLASS_NODATA = 2'd0;
    localparam logic [1:0] CLASS_UNDETECT = 2'd1;
    localparam logic [1:0] CLASS_DATA = 2'd2;

    typedef enum logic [2:0] {
        METHOD_FIRST   = 3'd0,
        METHOD_AVERAGE = 3'd1,
        METHOD_MINIMUM = 3'd2,
        METHOD_MAXIMUM = 3'd3,
        METHOD_NEAREST = 3'd4
    } t_method;

    typedef struct packed {
        t_method              method;
        logic [VALUE_W-1:0]   nodata;
        logic [VALUE_W-1:0]   undetect;
    } t_cfg;

    typedef enum logic [1:0] {
        KIND_SKIP  = 2'd0,
        KIND_UNDET = 2'd1,
        KIND_DATA  = 2'd2
    } t_kind;

    // One classified word travelling from front to back
    typedef struct packed {
        t_kind                kind;
        logic [VALUE_W-1:0]   value;
        logic [DIST_W-1:0]    distance;
        logic                 last;
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_DIVIDE = 2'd1,
        ST_EMIT   = 2'd2
    } t_back_state;

    function automatic logic is_data(input logic [VALUE_W-1:0] v,
                                     input logic [VALUE_W-1:0] nodata,
                                     input logic [VALUE_W-1:0] undetect);
        return (v != nodata) && (v != undetect);
    endfunction

endpackage

/* design/multi_source_pixel_compositor.sv */
// Top level of the multi-source pixel compositor.
//
// Input channel: one source sample per word (class, value, distance, distance
// flag, last-source mark), taken when push is high and full is low.
// Result channel: one composited byte per pixel, shown while empty is low and
// taken when pop is high. Config: i_cfg_we writes i_cfg_data to register
// i_cfg_index (0 method, 1 nodata code, 2 undetect code) at once.
// A last sample passes through the front register and the queue to the result
// register; under the average method a data sample also waits on the divider.
// Throughput: the back end takes one queued word per cycle in its idle state;
// a data sample under the average method holds it while the bit-serial divider
// recomputes the average, and a full result register can hold it as well.
// Reset clears the front register, the queue, the result register and the
// configuration; the next sample starts a new pixel.
// A stalled receiver keeps its result on the ports; the back end then waits
// on the next finished pixel, the two-word queue fills and full rises.
`timescale 1ns / 1ps
module multi_source_pixel_compositor
    import mspc_pkg::*;
#(
    parameter int MAX_SOURCES = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic [1:0]         i_sample_class,
    input  logic [VALUE_W-1:0] i_sample_value,
    input  logic [DIST_W-1:0]  i_distance_value,
    input  logic               i_distance_present,
    input  logic               i_last_source,
    output logic               empty,
    input  logic               pop,
    output logic [VALUE_W-1:0] o_pixel_value,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [VALUE_W-1:0] i_cfg_data
);

    t_cfg r_cfg;
    logic front_valid;
    t_op  front_op;
    logic q_full;
    logic q_valid;
    t_op  q_op;
    logic q_pop;

    // out-of-range method codes in the low three bits are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.method <= METHOD_FIRST;
            r_cfg.nodata <= '0;
            r_cfg.undetect <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_METHOD) begin
                if (i_cfg_data[2:0] <= METHOD_NEAREST) begin
                    r_cfg.method <= t_method'(i_cfg_data[2:0]);
                end
            end else if (i_cfg_index == CFG_NODATA) begin
                r_cfg.nodata <= i_cfg_data;
            end else if (i_cfg_index == CFG_UNDETECT) begin
                r_cfg.undetect <= i_cfg_data;
            end
        end
    end

    mspc_front u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_push             (push),
        .o_full             (full),
        .i_sample_class     (i_sample_class),
        .i_sample_value     (i_sample_value),
        .i_distance_value   (i_distance_value),
        .i_distance_present (i_distance_present),
        .i_last_source      (i_last_source),
        .i_method           (r_cfg.method),
        .o_valid            (front_valid),
        .o_op               (front_op),
        .i_q_full           (q_full)
    );

    mspc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (front_valid),
        .i_op    (front_op),
        .o_full  (q_full),
        .i_rd    (q_pop),
        .o_valid (q_valid),
        .o_op    (q_op)
    );

    mspc_back #(
        .MAX_SOURCES (MAX_SOURCES)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_q_valid     (q_valid),
        .i_q_op        (q_op),
        .o_q_pop       (q_pop),
        .i_pop         (pop),
        .o_empty       (empty),
        .o_pixel_value (o_pixel_value)
    );

endmodule

/* design/mspc_front.sv */
// Front stage: accepts samples and classifies them into operations.
`timescale 1ns / 1ps
module mspc_front
    import mspc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    output logic               o_full,
    input  logic [1:0]         i_sample_class,
    input  logic [VALUE_W-1:0] i_sample_value,
    input  logic [DIST_W-1:0]  i_distance_value,
    input  logic               i_distance_present,
    input  logic               i_last_source,
    input  t_method            i_method,
    output logic               o_valid,
    output t_op                o_op,
    input  logic               i_q_full
);

    logic r_valid;
    t_op  r_op;
    t_op  n_op;
    logic take;
    logic give;

    assign give = r_valid && !i_q_full;
    assign take = i_push && !o_full;
    assign o_full = r_valid && i_q_full;
    assign o_valid = r_valid;
    assign o_op = r_op;

    always_comb begin
        n_op.value = i_sample_value;
        n_op.distance = i_distance_value;
        n_op.last = i_last_source;
        // nearest method drops data words that carry no distance
        if (i_sample_class == CLASS_DATA) begin
            if (i_method == METHOD_NEAREST && !i_distance_present) begin
                n_op.kind = KIND_SKIP;
            end else begin
                n_op.kind = KIND_DATA;
            end
        end else if (i_sample_class == CLASS_UNDETECT) begin
            n_op.kind = KIND_UNDET;
        end else begin
            n_op.kind = KIND_SKIP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= 1'b1;
        end else if (give) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_op <= n_op;
        end
    end

endmodule

/* design/mspc_queue.sv */
// Short FIFO of classified operations between front and back.
`timescale 1ns / 1ps
module mspc_queue
    import mspc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr,
    input  t_op  i_op,
    output logic o_full,
    input  logic i_rd,
    output logic o_valid,
    output t_op  o_op
);

    t_op               r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QCNT_W-1:0] r_count;
    logic              wr_en;
    logic              rd_en;

    assign o_full = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_op = r_mem[r_rptr];
    assign wr_en = i_wr && !o_full;
    assign rd_en = i_rd && o_valid;

    function automatic logic [QPTR_W-1:0] bump(input logic [QPTR_W-1:0] p);
        if (p == QPTR_W'(QUEUE_DEPTH - 1)) begin
            return '0;
        end
        return p + QPTR_W'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_count <= '0;
        end else begin
            if (wr_en) begin
                r_wptr <= bump(r_wptr);
            end
            if (rd_en) begin
                r_rptr <= bump(r_rptr);
            end
            if (wr_en && !rd_en) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (rd_en && !wr_en) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wptr] <= i_op;
        end
    end

endmodule

/* design/mspc_divider.sv */
// Restoring divider for the running average, one quotient bit per cycle.
`timescale 1ns / 1ps
module mspc_divider
    import mspc_pkg::*;
#(
    parameter int DIVISOR_W = 5
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [DIVISOR_W+VALUE_W-1:0] i_dividend,
    input  logic [DIVISOR_W-1:0]         i_divisor,
    output logic                         o_last_step,
    output logic [VALUE_W-1:0]           o_quotient
);

    localparam int STEP_W = $clog2(VALUE_W);

    logic                 r_busy;
    logic [STEP_W-1:0]    r_step;
    logic [DIVISOR_W-1:0] r_rem;
    logic [DIVISOR_W-1:0] r_div;
    logic [VALUE_W-1:0]   r_quo;
    logic [DIVISOR_W:0]   shifted;
    logic [DIVISOR_W:0]   diff;
    logic                 ge;
    logic [DIVISOR_W-1:0] n_rem;
    logic [VALUE_W-1:0]   n_quo;

    // quotient is an average of bytes, so it fits VALUE_W bits and the
    // dividend's upper part starts below the divisor
    assign shifted = {r_rem, r_quo[VALUE_W-1]};
    assign ge = (shifted >= {1'b0, r_div});
    assign diff = shifted - {1'b0, r_div};
    assign n_rem = ge ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
    assign n_quo = {r_quo[VALUE_W-2:0], ge};
    assign o_last_step = r_busy && (r_step == STEP_W'(VALUE_W - 1));
    assign o_quotient = n_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_step <= '0;
        end else if (r_busy) begin
            r_step <= r_step + STEP_W'(1);
            if (o_last_step) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_dividend[DIVISOR_W+VALUE_W-1:VALUE_W];
            r_quo <= i_dividend[VALUE_W-1:0];
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

endmodule

/* design/mspc_back.sv */
// Back stage: per-pixel accumulation, averaging and the result register.
`timescale 1ns / 1ps
module mspc_back
    import mspc_pkg::*;
#(
    parameter int MAX_SOURCES = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  logic               i_q_valid,
    input  t_op                i_q_op,
    output logic               o_q_pop,
    input  logic               i_pop,
    output logic               o_empty,
    output logic [VALUE_W-1:0] o_pixel_value
);

    localparam int CNT_W = $clog2(MAX_SOURCES + 1);
    localparam int SUM_W = CNT_W + VALUE_W;

    t_back_state        r_state, n_state;
    logic               r_pixel_start, n_pixel_start;
    logic [VALUE_W-1:0] r_cur, n_cur;
    logic [VALUE_W-1:0] r_least, n_least;
    logic [VALUE_W-1:0] r_great, n_great;
    logic [SUM_W-1:0]   r_sum, n_sum;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [LDIST_W-1:0] r_dist, n_dist;
    logic               r_first, n_first;
    logic               r_last, n_last;
    logic               r_out_valid, n_out_valid;
    logic [VALUE_W-1:0] r_out_value, n_out_value;

    logic [VALUE_W-1:0] eff_cur, eff_least, eff_great;
    logic [SUM_W-1:0]   eff_sum;
    logic [CNT_W-1:0]   eff_cnt;
    logic [LDIST_W-1:0] eff_dist;
    logic               eff_first;
    logic               out_free;
    logic               div_start;
    logic               div_last_step;
    logic [VALUE_W-1:0] div_quotient;

    // a new pixel reads as freshly cleared state
    assign eff_cur = r_pixel_start ? i_cfg.nodata : r_cur;
    assign eff_least = r_pixel_start ? i_cfg.nodata : r_least;
    assign eff_great = r_pixel_start ? i_cfg.nodata : r_great;
    assign eff_sum = r_pixel_start ? '0 : r_sum;
    assign eff_cnt = r_pixel_start ? '0 : r_cnt;
    assign eff_dist = r_pixel_start ? '1 : r_dist;
    assign eff_first = r_pixel_start ? 1'b0 : r_first;

    assign out_free = !r_out_valid || i_pop;
    assign o_empty = !r_out_valid;
    assign o_pixel_value = r_out_value;

    mspc_divider #(
        .DIVISOR_W (CNT_W)
    ) u_divider (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (n_sum),
        .i_divisor   (n_cnt),
        .o_last_step (div_last_step),
        .o_quotient  (div_quotient)
    );

    always_comb begin
        n_state = r_state;
        n_pixel_start = r_pixel_start;
        n_cur = r_cur;
        n_least = r_least;
        n_great = r_great;
        n_sum = r_sum;
        n_cnt = r_cnt;
        n_dist = r_dist;
        n_first = r_first;
        n_last = r_last;
        n_out_valid = r_out_valid && !i_pop;
        n_out_value = r_out_value;
        o_q_pop = 1'b0;
        div_start = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_pixel_start = 1'b0;
                    n_cur = eff_cur;
                    n_least = eff_least;
                    n_great = eff_great;
                    n_sum = eff_sum;
                    n_cnt = eff_cnt;
                    n_dist = eff_dist;
                    n_first = eff_first;
                    n_last = i_q_op.last;
                    // first method ignores everything after its hit
                    if (!(i_cfg.method == METHOD_FIRST && eff_first)) begin
                        if (i_q_op.kind == KIND_DATA) begin
                            unique case (i_cfg.method)
                                METHOD_FIRST: begin
                                    n_cur = i_q_op.value;
                                    n_first = 1'b1;
                                end
                                METHOD_AVERAGE: begin
                                    if (eff_cnt < CNT_W'(MAX_SOURCES)) begin
                                        n_sum = eff_sum + SUM_W'(i_q_op.value);
                                        n_cnt = eff_cnt + CNT_W'(1);
                                        div_start = 1'b1;
                                    end
                                end
                                METHOD_MINIMUM: begin
                                    if (!is_data(eff_least, i_cfg.nodata, i_cfg.undetect)
                                            || eff_least > i_q_op.value) begin
                                        n_least = i_q_op.value;
                                    end
                                    n_cur = n_least;
                                end
                                METHOD_MAXIMUM: begin
                                    if (!is_data(eff_great, i_cfg.nodata, i_cfg.undetect)
                                            || eff_great < i_q_op.value) begin
                                        n_great = i_q_op.value;
                                    end
                                    n_cur = n_great;
                                end
                                METHOD_NEAREST: begin
                                    if (LDIST_W'(i_q_op.distance) < eff_dist) begin
                                        n_dist = LDIST_W'(i_q_op.distance);
                                        n_cur = i_q_op.value;
                                    end
                                end
                                default: begin
                                end
                            endcase
                        end else if (i_q_op.kind == KIND_UNDET) begin
                            if (!is_data(eff_cur, i_cfg.nodata, i_cfg.undetect)) begin
                                n_cur = i_cfg.undetect;
                            end
                        end
                    end
                    if (div_start) begin
                        n_state = ST_DIVIDE;
                    end else if (i_q_op.last) begin
                        if (out_free) begin
                            n_out_valid = 1'b1;
                            n_out_value = n_cur;
                            n_pixel_start = 1'b1;
                        end else begin
                            n_state = ST_EMIT;
                        end
                    end
                end
            end
            ST_DIVIDE: begin
                if (div_last_step) begin
                    n_cur = div_quotient;
                    if (r_last) begin
                        if (out_free) begin
                            n_out_valid = 1'b1;
                            n_out_value = div_quotient;
                            n_pixel_start = 1'b1;
                            n_state = ST_IDLE;
                        end else begin
                            n_state = ST_EMIT;
                        end
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_value = r_cur;
                    n_pixel_start = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pixel_start <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pixel_start <= n_pixel_start;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur <= n_cur;
        r_least <= n_least;
        r_great <= n_great;
        r_sum <= n_sum;
        r_cnt <= n_cnt;
        r_dist <= n_dist;
        r_first <= n_first;
        r_last <= n_last;
        r_out_value <= n_out_value;
    end

endmodule

/* design/mspc_checker.sv */
// Port-level checks of the compositor, bound to the top level.
`timescale 1ns / 1ps
`include "multi_source_pixel_compositor_macros.svh"
module mspc_checker
    import mspc_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_push,
    input logic               i_full,
    input logic               i_empty,
    input logic               i_pop,
    input logic [VALUE_W-1:0] i_pixel_value
);

    // nothing pending right after reset
    `MSPC_ASSERT_NOW(a_reset_clear, i_clk, i_rst_n, $past(!i_rst_n), i_empty && !i_full, "not clear after reset")

    // the front register and queue only fill from an accepted word
    `MSPC_ASSERT_NOW(a_full_cause, i_clk, i_rst_n, $rose(i_full), $past(i_push && !i_full), "full rose without an accepted word")

    // a waiting result holds until taken
    `MSPC_ASSERT_NEXT(a_result_hold, i_clk, i_rst_n, !i_empty && !i_pop, !i_empty && $stable(i_pixel_value), "result changed while waiting")

endmodule

bind multi_source_pixel_compositor mspc_checker u_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_push        (push),
    .i_full        (full),
    .i_empty       (empty),
    .i_pop         (pop),
    .i_pixel_value (o_pixel_value)
);
